@@ rtl/vmsp_pkg.sv @@
`default_nettype none

package vmsp_pkg;

    localparam int WIN_LEN = 4;

    typedef logic [7:0] octet_t;

    // mode pattern 0A 00 (24|04) 86
    localparam octet_t PAT_B0     = 8'h0A;
    localparam octet_t PAT_B1     = 8'h00;
    localparam octet_t PAT_B2_HI  = 8'h24;
    localparam octet_t PAT_B2_LO  = 8'h04;
    localparam octet_t PAT_B3     = 8'h86;
    localparam octet_t MODE_ADJ   = 8'd2;

    // follow-up instruction: byte 2 in 90..93, byte 3 is 24
    localparam octet_t FOLLOW_MIN = 8'h90;
    localparam octet_t FOLLOW_MAX = 8'h93;
    localparam octet_t FOLLOW_B3  = 8'h24;

    localparam logic [3:0] CD_RELOAD = 4'd10;
    localparam logic [3:0] CD_FIRST  = 4'd5;
    localparam logic [3:0] CD_SECOND = 4'd4;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE_FIX   = 3'd0,
        CFG_POS_FIX    = 3'd1,
        CFG_SCR_FIX    = 3'd2,
        CFG_SCR_BASE   = 3'd3,
        CFG_POS_FIRST  = 3'd4,
        CFG_POS_SECOND = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic        mode_fix;
        logic        pos_fix;
        logic        scr_fix;
        octet_t      screen_base;
        logic [15:0] pos_first;
        logic [15:0] pos_second;
    } cfg_t;

    // results caused by one request: up to four bytes, count 0..4
    typedef struct packed {
        octet_t [WIN_LEN-1:0] bytes;
        logic   [2:0]         count;
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/vmsp_in_if.sv @@
`default_nettype none

interface vmsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_end;

    modport source (output valid, output in_byte, output stream_end, input ready);
    modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

`default_nettype wire

@@ rtl/vmsp_out_if.sv @@
`default_nettype none

interface vmsp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/vmsp_front.sv @@
`default_nettype none

module vmsp_front
    import vmsp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    vmsp_in_if.sink            feed,
    input  wire cfg_t          cfg,
    input  wire queue_status_t q_status,
    output      logic          push,
    output      group_t        push_group
);

    octet_t [WIN_LEN-1:0] win_reg;
    octet_t [WIN_LEN-1:0] win_next;
    logic   [1:0]         fill_reg;
    logic   [1:0]         fill_next;
    logic   [3:0]         cd_reg;
    logic   [3:0]         cd_next;

    octet_t [WIN_LEN-1:0] win_now;
    octet_t [WIN_LEN-1:0] patched;
    logic   [3:0]         cd_dec;
    logic   [15:0]        pos_val;
    logic                 accept;
    logic                 full;
    logic                 pattern;
    logic                 follow;

    assign feed.ready = !q_status.full;
    assign accept     = feed.valid && feed.ready;

    always_comb
    begin
        win_now           = win_reg;
        win_now[fill_reg] = feed.in_byte;
        full              = (fill_reg == 2'd3);
        cd_dec            = (cd_reg != 4'd0) ? cd_reg - 4'd1 : cd_reg;

        pattern = (win_now[0] == PAT_B0) && (win_now[1] == PAT_B1)
               && ((win_now[2] == PAT_B2_HI) || (win_now[2] == PAT_B2_LO))
               && (win_now[3] == PAT_B3);
        follow  = ((cd_dec == CD_FIRST) || (cd_dec == CD_SECOND))
               && (win_now[2] inside {[FOLLOW_MIN:FOLLOW_MAX]})
               && (win_now[3] == FOLLOW_B3);

        pos_val = (cd_dec == CD_FIRST) ? cfg.pos_first : cfg.pos_second;
        patched = win_now;
        if (pattern)
        begin
            if (cfg.mode_fix)
            begin
                patched[0] = win_now[0] - MODE_ADJ;
                patched[3] = win_now[3] - MODE_ADJ;
            end
        end
        else
        begin
            if (cfg.pos_fix)
            begin
                patched[0] = pos_val[7:0];
                patched[1] = pos_val[15:8];
            end
            if (cfg.scr_fix && (win_now[2] > cfg.screen_base))
                patched[2] = win_now[2] - 8'd1;
        end

        // result group for this request
        push_group.bytes = (full && (pattern || follow)) ? patched : win_now;
        if (full)
            push_group.count = (pattern || follow || feed.stream_end) ? 3'd4 : 3'd1;
        else
            push_group.count = feed.stream_end ? ({1'b0, fill_reg} + 3'd1) : 3'd0;
        push = accept && (push_group.count != 3'd0);

        // window update
        win_next  = win_now;
        fill_next = fill_reg + 2'd1;
        cd_next   = cd_reg;
        if (full)
        begin
            cd_next = (pattern && (cfg.pos_fix || cfg.scr_fix)) ? CD_RELOAD : cd_dec;
            if (pattern || follow)
                fill_next = 2'd0;
            else
            begin
                win_next  = {8'h00, win_now[3], win_now[2], win_now[1]};
                fill_next = 2'd3;
            end
        end
        if (feed.stream_end)
        begin
            fill_next = 2'd0;
            cd_next   = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            cd_reg   <= 4'd0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            cd_reg   <= cd_next;
        end
    end

    // bytes beyond the fill level are never read
    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

endmodule

`default_nettype wire

@@ rtl/vmsp_queue.sv @@
`default_nettype none

module vmsp_queue
    import vmsp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire group_t        push_group,
    input  wire logic          pop,
    output      group_t        head,
    output      queue_status_t status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    group_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_group;
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_FULL);
    assign status.empty = (cnt_reg == '0);

endmodule

`default_nettype wire

@@ rtl/vmsp_back.sv @@
`default_nettype none

module vmsp_back
    import vmsp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire group_t        head,
    input  wire queue_status_t q_status,
    output      logic          pop,
    vmsp_out_if.source         result
);

    logic         out_valid_reg;
    octet_t       out_byte_reg;
    logic         out_last_reg;
    logic [1:0]   idx_reg;
    logic [1:0]   idx_next;
    logic         load;
    logic         last_of_group;

    assign load          = !q_status.empty && (!out_valid_reg || result.ready);
    assign last_of_group = ({1'b0, idx_reg} == (head.count - 3'd1));
    assign pop           = load && last_of_group;
    assign idx_next      = last_of_group ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            out_last_reg <= last_of_group;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.run_last = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/video_mode_stream_patcher.sv @@
`default_nettype none

// channel   dir  payload                     handshake
// feed      in   in_byte[7:0], stream_end    valid/ready
// result    out  out_byte[7:0], run_last     valid/ready
// cfg       in   cfg_index[2:0], cfg_data    cfg_we, no back-pressure
//
// one byte is taken per cycle while the group queue has room
// a byte causes zero to four result bytes; the result port sends one a cycle
//   while results are queued and the receiver is ready
// the first result of a request passes through the group queue and the output register
// reset clears window fill, countdown, queue and output valid; no clearing pass
// a full group queue drops feed.ready; output stall never changes held data

module video_mode_stream_patcher
    import vmsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    vmsp_in_if.sink                     feed,
    vmsp_out_if.source                  result,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t          cfg_reg;
    group_t        push_group;
    group_t        head;
    queue_status_t q_status;
    logic          push;
    logic          pop;

    // register file: the user writes it only while idle; not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_fix    <= 1'b1;
            cfg_reg.pos_fix     <= 1'b0;
            cfg_reg.scr_fix     <= 1'b0;
            cfg_reg.screen_base <= 8'd144;
            cfg_reg.pos_first   <= 16'd3;
            cfg_reg.pos_second  <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE_FIX:   cfg_reg.mode_fix    <= cfg_data[0];
                CFG_POS_FIX:    cfg_reg.pos_fix     <= cfg_data[0];
                CFG_SCR_FIX:    cfg_reg.scr_fix     <= cfg_data[0];
                CFG_SCR_BASE:   cfg_reg.screen_base <= cfg_data[7:0];
                CFG_POS_FIRST:  cfg_reg.pos_first   <= cfg_data;
                CFG_POS_SECOND: cfg_reg.pos_second  <= cfg_data;
                default:        ; // unknown index, write dropped
            endcase
        end
    end

    // front: window, countdown and patch decision, at most one group per request
    vmsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .cfg        (cfg_reg),
        .q_status   (q_status),
        .push       (push),
        .push_group (push_group)
    );

    // groups wait here so output stalls do not stop the front at once
    vmsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // back: serializes each group onto the result port, last byte flagged
    vmsp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ rtl/vmsp_checker.sv @@
`default_nettype none

module vmsp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       feed_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [7:0] res_byte,
    input wire logic       res_last
);

    logic [1:0] run_cnt_reg;
    logic       res_fire;

    assign res_fire = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_cnt_reg <= 2'd0;
        else if (res_fire)
            run_cnt_reg <= res_last ? 2'd0 : run_cnt_reg + 2'd1;
    end

    // stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_last))
        else $error("result changed while stalled");

    // nothing to send right after reset
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid right after reset");

    // a full queue always has a byte on the port
    assert property (@(posedge clk) disable iff (!rst_n)
        !feed_ready |-> res_valid)
        else $error("feed stalled with idle result port");

    // a request never causes more than four results
    assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && !res_last |-> run_cnt_reg != 2'd3)
        else $error("run longer than four results");

endmodule

bind video_mode_stream_patcher vmsp_checker u_vmsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .feed_ready (feed.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_byte   (result.out_byte),
    .res_last   (result.run_last)
);

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import vmsp_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 48;
    localparam int MAX_SHOWN     = 10;
    localparam int MAX_GAP       = 14;

    // register indexes past the end of the list, writes there change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    // one patched output byte as it should leave the block
    typedef struct packed {
        octet_t data;
        logic   is_last;
    } out_rec_t;

    typedef enum logic { ROW_FEED, ROW_REG } row_kind_t;

    // directed stimulus row: a feed byte or a register write
    // typed rows carry their own expected bytes instead of the predictor's
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  value;
        logic                   end_flag;
        logic                   typed;
        logic [2:0]             n_typed;
        octet_t [3:0]           typed_bytes;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    vmsp_in_if  feed_ch ();
    vmsp_out_if res_ch ();

    video_mode_stream_patcher uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .feed      (feed_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: settings, four-byte window, fill level and countdown
    cfg_t       live_cfg;
    octet_t     win_bytes [4];
    int         win_fill;
    logic [3:0] countdown;

    // patched bytes still owed by the block, oldest first
    out_rec_t   pending_out [$];
    stim_row_t  stim_rows [$];

    // flow control knobs for the feed and drain sides
    bit fast_feed;
    bit fast_drain;
    bit hold_req;
    bit hold_asked;

    int bytes_in;
    int bytes_out;
    int mode_hits;
    int follow_hits;
    int stream_ends;
    int settings_used;
    int in_stall_cycles;
    int fail_count;
    int cycles;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void reset_predictor();
        live_cfg.mode_fix    = 1'b1;
        live_cfg.pos_fix     = 1'b0;
        live_cfg.scr_fix     = 1'b0;
        live_cfg.screen_base = 8'd144;
        live_cfg.pos_first   = 16'd3;
        live_cfg.pos_second  = 16'd0;
        foreach (win_bytes[k])
            win_bytes[k] = 8'h00;
        win_fill  = 0;
        countdown = 4'd0;
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            CFG_MODE_FIX:   live_cfg.mode_fix    = v[0];
            CFG_POS_FIX:    live_cfg.pos_fix     = v[0];
            CFG_SCR_FIX:    live_cfg.scr_fix     = v[0];
            CFG_SCR_BASE:   live_cfg.screen_base = v[7:0];
            CFG_POS_FIRST:  live_cfg.pos_first   = v;
            CFG_POS_SECOND: live_cfg.pos_second  = v;
            default: ;
        endcase
    endfunction

    // one input byte in, zero to four patched bytes out (outs[0] goes first)
    function automatic int patch_predict(input octet_t b, input logic end_flag,
                                         output octet_t [3:0] outs);
        int          n;
        int          k;
        logic [15:0] halfword;
        n    = 0;
        outs = '0;
        if (win_fill > 3)
            win_fill = 3;
        win_bytes[win_fill] = b;
        win_fill++;

        if (win_fill == 4)
        begin
            if (countdown != 4'd0)
                countdown = countdown - 4'd1;

            if (win_bytes[0] == PAT_B0 && win_bytes[1] == PAT_B1 &&
                (win_bytes[2] == PAT_B2_HI || win_bytes[2] == PAT_B2_LO) &&
                win_bytes[3] == PAT_B3)
            begin
                // mode instruction: may arm the countdown and adjust the mode bytes
                mode_hits++;
                if (live_cfg.pos_fix || live_cfg.scr_fix)
                    countdown = CD_RELOAD;
                if (live_cfg.mode_fix)
                begin
                    win_bytes[0] = win_bytes[0] - MODE_ADJ;
                    win_bytes[3] = win_bytes[3] - MODE_ADJ;
                end
                for (k = 0; k < 4; k++)
                    outs[n++] = win_bytes[k];
                win_fill = 0;
            end
            else if ((countdown == CD_FIRST || countdown == CD_SECOND) &&
                     win_bytes[2] >= FOLLOW_MIN && win_bytes[2] <= FOLLOW_MAX &&
                     win_bytes[3] == FOLLOW_B3)
            begin
                // follow-up instruction a few windows after a mode pattern
                follow_hits++;
                if (live_cfg.pos_fix)
                begin
                    halfword     = (countdown == CD_FIRST) ? live_cfg.pos_first
                                                           : live_cfg.pos_second;
                    win_bytes[0] = halfword[7:0];
                    win_bytes[1] = halfword[15:8];
                end
                if (live_cfg.scr_fix && win_bytes[2] > live_cfg.screen_base)
                    win_bytes[2] = win_bytes[2] - 8'd1;
                for (k = 0; k < 4; k++)
                    outs[n++] = win_bytes[k];
                win_fill = 0;
            end
            else
            begin
                // no match: oldest byte leaves, window slides down
                outs[n++]    = win_bytes[0];
                win_bytes[0] = win_bytes[1];
                win_bytes[1] = win_bytes[2];
                win_bytes[2] = win_bytes[3];
                win_bytes[3] = 8'h00;
                win_fill     = 3;
            end
        end

        if (end_flag)
        begin
            // flush what is left untouched and start the next stream clean
            for (k = 0; k < win_fill; k++)
                outs[n++] = win_bytes[k];
            foreach (win_bytes[j])
                win_bytes[j] = 8'h00;
            win_fill  = 0;
            countdown = 4'd0;
        end
        return n;
    endfunction

    function automatic void push_results(input int n, input octet_t [3:0] outs);
        out_rec_t rec;
        for (int k = 0; k < n; k++)
        begin
            rec.data    = outs[k];
            rec.is_last = (k == n - 1);
            pending_out.push_back(rec);
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    function automatic void note_error(string msg);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endfunction

    function automatic void check_result(octet_t got_byte, logic got_last);
        out_rec_t want;
        bytes_out++;
        if (pending_out.size() == 0)
        begin
            note_error($sformatf("unexpected out_byte %02h run_last %0b", got_byte, got_last));
            return;
        end
        want = pending_out.pop_front();
        if (got_byte !== want.data)
            note_error($sformatf("out_byte expected %02h got %02h", want.data, got_byte));
        if (got_last !== want.is_last)
            note_error($sformatf("run_last expected %0b got %0b", want.is_last, got_last));
    endfunction

    // ------------------------------------------------------------------
    // directed rows
    // ------------------------------------------------------------------

    function automatic void add_feed(octet_t b, logic end_flag);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_FEED;
        r.value    = {8'h00, b};
        r.end_flag = end_flag;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_typed(octet_t b, logic end_flag, logic [2:0] n,
                                      octet_t x0, octet_t x1, octet_t x2, octet_t x3);
        stim_row_t r;
        r             = '0;
        r.kind        = ROW_FEED;
        r.value       = {8'h00, b};
        r.end_flag    = end_flag;
        r.typed       = 1'b1;
        r.n_typed     = n;
        r.typed_bytes = {x3, x2, x1, x0};
        stim_rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.value     = v;
        stim_rows.push_back(r);
    endfunction

    function automatic void build_rows();
        // reset settings: mode fix on, position and screen fixes off
        add_typed(PAT_B0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_typed(PAT_B1, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_typed(PAT_B2_HI, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_typed(PAT_B3, 1'b0, 3'd4, 8'h08, 8'h00, 8'h24, 8'h84);
        // single-byte stream, all ones
        add_typed(8'hFF, 1'b1, 3'd1, 8'hFF, 8'h00, 8'h00, 8'h00);
        // full window with no match, then the end flushes the three left over
        add_feed(8'h00, 1'b0);
        add_feed(8'hFF, 1'b0);
        add_feed(8'h55, 1'b0);
        add_typed(8'hAA, 1'b1, 3'd4, 8'h00, 8'hFF, 8'h55, 8'hAA);

        // every register, plus the two unused indexes
        add_reg(CFG_MODE_FIX, 16'hFFFE);
        add_reg(CFG_POS_FIX, 16'h0001);
        add_reg(CFG_SCR_FIX, 16'h8001);
        add_reg(CFG_SCR_BASE, 16'hA591);
        add_reg(CFG_POS_FIRST, 16'hBEEF);
        add_reg(CFG_POS_SECOND, 16'h1234);
        add_reg(CFG_SPARE_A, 16'hFFFF);
        add_reg(CFG_SPARE_B, 16'h0001);

        // low pattern variant, then both follow-ups at countdown 5 and 4
        add_feed(PAT_B0, 1'b0);
        add_feed(PAT_B1, 1'b0);
        add_feed(PAT_B2_LO, 1'b0);
        add_feed(PAT_B3, 1'b0);
        add_feed(8'h11, 1'b0);
        add_feed(8'h22, 1'b0);
        add_feed(8'h33, 1'b0);
        add_feed(8'h44, 1'b0);
        add_feed(8'h55, 1'b0);
        add_feed(8'h66, 1'b0);
        add_feed(FOLLOW_MIN + 8'd1, 1'b0);  // equal to the base, no decrement
        add_feed(FOLLOW_B3, 1'b0);
        add_feed(8'h77, 1'b0);
        add_feed(8'h88, 1'b0);
        add_feed(FOLLOW_MAX, 1'b0);         // above the base, decremented
        add_feed(FOLLOW_B3, 1'b0);
        add_feed(8'hC3, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // feed side
    // ------------------------------------------------------------------

    // offer one request and return at the edge where it is taken
    // valid stays high across back-to-back requests
    task automatic send_byte(input octet_t b, input logic end_flag);
        int gap;
        gap = fast_feed ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            feed_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        feed_ch.valid      <= 1'b1;
        feed_ch.in_byte    <= b;
        feed_ch.stream_end <= end_flag;
        do
            @(posedge clk);
        while (!feed_ch.ready);
        bytes_in++;
        if (end_flag)
            stream_ends++;
    endtask

    task automatic feed_and_predict(input octet_t b, input logic end_flag);
        octet_t [3:0] outs;
        int           n;
        send_byte(b, end_flag);
        n = patch_predict(b, end_flag, outs);
        push_results(n, outs);
    endtask

    // wait for the block to go quiet before touching its registers
    // bytes parked in the window produce nothing, so allow a few extra cycles
    task automatic settle(input int extra);
        feed_ch.valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // one write per edge, cfg_we left high for the caller to drop
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        apply_reg(idx, v);
    endtask

    function automatic logic [CFG_DATA_W-1:0] flag_word(bit en);
        logic [CFG_DATA_W-1:0] w;
        w    = 16'($urandom_range(0, 65535));
        w[0] = en;
        return w;
    endfunction

    task automatic set_phase_regs(input int p);
        logic [CFG_DATA_W-1:0] base_word;
        base_word = 16'($urandom_range(0, 65535));
        if (p == 0)
        begin
            // everything on, decrement forced by a zero base
            write_reg(CFG_MODE_FIX, flag_word(1'b1));
            write_reg(CFG_POS_FIX, flag_word(1'b1));
            write_reg(CFG_SCR_FIX, flag_word(1'b1));
            write_reg(CFG_SCR_BASE, {base_word[15:8], 8'h00});
            write_reg(CFG_POS_FIRST, 16'hFFFF);
            write_reg(CFG_POS_SECOND, 16'h0000);
        end
        else if (p == 1)
        begin
            // mode fix off, base at the top so no decrement can happen
            write_reg(CFG_MODE_FIX, flag_word(1'b0));
            write_reg(CFG_POS_FIX, flag_word(1'b1));
            write_reg(CFG_SCR_FIX, flag_word(1'b1));
            write_reg(CFG_SCR_BASE, {base_word[15:8], 8'hFF});
            write_reg(CFG_POS_FIRST, 16'h0000);
            write_reg(CFG_POS_SECOND, 16'hFFFF);
        end
        else
        begin
            // base mostly right around the follow-up range
            if ($urandom_range(0, 3) != 0)
                base_word[7:0] = 8'($urandom_range(FOLLOW_MIN - 1, FOLLOW_MAX));
            write_reg(CFG_MODE_FIX, flag_word($urandom_range(0, 1) != 0));
            write_reg(CFG_POS_FIX, flag_word($urandom_range(0, 3) != 0));
            write_reg(CFG_SCR_FIX, flag_word($urandom_range(0, 3) != 0));
            write_reg(CFG_SCR_BASE, base_word);
            write_reg(CFG_POS_FIRST, flag_word($urandom_range(0, 1) != 0));
            write_reg(CFG_POS_SECOND, flag_word($urandom_range(0, 1) != 0));
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // byte 2 of a follow-up: mostly in range, sometimes anything
    function automatic octet_t follow_mid();
        if ($urandom_range(0, 5) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(FOLLOW_MIN, FOLLOW_MAX));
    endfunction

    function automatic octet_t follow_tail();
        if ($urandom_range(0, 5) == 0)
            return 8'($urandom_range(0, 255));
        return FOLLOW_B3;
    endfunction

    // one random request sequence, counted into count
    task automatic run_sequence(inout int count);
        octet_t seq [$];
        int     kind;
        int     len;
        int     k;
        bit     end_at_tail;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            // mode pattern, at times corrupted, then mostly fillers and two follow-ups
            seq.push_back(PAT_B0);
            seq.push_back(PAT_B1);
            seq.push_back($urandom_range(0, 1) ? PAT_B2_HI : PAT_B2_LO);
            seq.push_back(PAT_B3);
            if ($urandom_range(0, 7) == 0)
                seq[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) != 0)
            begin
                // four fillers, the halfword slot, then byte 2 and byte 3
                for (k = 0; k < 6; k++)
                    seq.push_back(8'($urandom_range(0, 255)));
                seq.push_back(follow_mid());
                seq.push_back(follow_tail());
                seq.push_back(8'($urandom_range(0, 255)));
                seq.push_back(8'($urandom_range(0, 255)));
                seq.push_back(follow_mid());
                seq.push_back(follow_tail());
                len = $urandom_range(0, 3);
                for (k = 0; k < len; k++)
                    seq.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 8)
        begin
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++)
                seq.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 8)
        begin
            // short stream, flushed right away
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++)
                seq.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // bytes drawn from the interesting values only
            len = $urandom_range(4, 12);
            for (k = 0; k < len; k++)
            begin
                case ($urandom_range(0, 5))
                    0: seq.push_back(PAT_B0);
                    1: seq.push_back(PAT_B1);
                    2: seq.push_back(PAT_B2_HI);
                    3: seq.push_back(PAT_B2_LO);
                    4: seq.push_back(PAT_B3);
                    default: seq.push_back(8'($urandom_range(FOLLOW_MIN, FOLLOW_MAX)));
                endcase
            end
        end
        end_at_tail = (kind == 8) || ($urandom_range(0, 2) == 0);
        for (k = 0; k < seq.size(); k++)
        begin
            feed_and_predict(seq[k], end_at_tail && (k == seq.size() - 1));
            count++;
        end
    endtask

    // ------------------------------------------------------------------
    // clock, watchdog, drain side
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d bytes still owed", cycles, pending_out.size());
        $display("status: fail");
        $finish;
    end

    // input back-pressure, mostly from the long hold-off below
    always @(posedge clk)
    begin
        if (rst_n && feed_ch.valid && !feed_ch.ready)
            in_stall_cycles++;
    end

    // result side: random or no stall before each byte, one long hold-off on request
    initial
    begin
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = fast_drain ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
            check_result(res_ch.out_byte, res_ch.run_last);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        stim_row_t    row;
        octet_t [3:0] outs;
        int           n;
        int           i;
        int           p;
        int           phase_count;
        bit           in_writes;

        rst_n              <= 1'b0;
        feed_ch.valid      <= 1'b0;
        feed_ch.in_byte    <= 8'h00;
        feed_ch.stream_end <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_MODE_FIX;
        cfg_data           <= '0;
        fast_feed   = 1'b0;
        fast_drain  = 1'b0;
        hold_req    = 1'b0;
        hold_asked  = 1'b0;
        in_writes   = 1'b0;
        reset_predictor();
        build_rows();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: a run of register rows waits for the block to drain first
        for (i = 0; i < stim_rows.size(); i++)
        begin
            row = stim_rows[i];
            if (row.kind == ROW_REG)
            begin
                if (!in_writes)
                    settle(SETTLE_CYCLES);
                write_reg(row.reg_index, row.value);
                in_writes = 1'b1;
            end
            else
            begin
                if (in_writes)
                begin
                    cfg_we <= 1'b0;
                    in_writes = 1'b0;
                    settings_used++;
                end
                send_byte(row.value[7:0], row.end_flag);
                n = patch_predict(row.value[7:0], row.end_flag, outs);
                if (row.typed)
                    push_results(int'(row.n_typed), row.typed_bytes);
                else
                    push_results(n, outs);
            end
        end

        // random phases, each under fresh settings
        // phase 2 feeds flat out and asks for one long receiver hold-off
        for (p = 0; p < PHASES; p++)
        begin
            settle(SETTLE_CYCLES);
            set_phase_regs(p);
            fast_feed   = (p == 2) || ($urandom_range(0, 3) == 0);
            fast_drain  = ($urandom_range(0, 3) == 0);
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                if (p == 2 && phase_count >= 8 && !hold_asked)
                begin
                    hold_req   = 1'b1;
                    hold_asked = 1'b1;
                end
                run_sequence(phase_count);
            end
        end

        settle(TAIL_CYCLES);

        $display("sent %0d bytes, checked %0d patched bytes under %0d register settings",
                 bytes_in, bytes_out, settings_used);
        $display("saw %0d mode patterns, %0d follow-ups, %0d stream ends, input held %0d cycles",
                 mode_hits, follow_hits, stream_ends, in_stall_cycles);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/vmsp_pkg.sv
rtl/vmsp_in_if.sv
rtl/vmsp_out_if.sv
rtl/vmsp_front.sv
rtl/vmsp_queue.sv
rtl/vmsp_back.sv
rtl/video_mode_stream_patcher.sv
rtl/vmsp_checker.sv
tb/tb.sv
